FILE: hdl/b36uid_pkg.sv
// types, constants and helper functions shared by the base-36 uid parser
package b36uid_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned DIGIT_W  = 6;
  // product of a 64-bit value and 36 plus a digit fits in 70 bits
  localparam int unsigned WIDE_W   = VALUE_W + 6;

  localparam logic [POS_W-1:0] PREFIX_LEN = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_PREFIX = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_BODY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_DIGIT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd4;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0]    prefix_pos;
    logic [VALUE_W-1:0]  acc;
    logic [STATUS_W-1:0] err;
    logic                body_seen;
  } parse_state_t;

  // expected character of the "uid://" prefix at a given position
  function automatic logic [CHAR_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] ch;
    case (pos)
      3'd0:    ch = 8'h75; // u
      3'd1:    ch = 8'h69; // i
      3'd2:    ch = 8'h64; // d
      3'd3:    ch = 8'h3a; // :
      3'd4:    ch = 8'h2f; // /
      3'd5:    ch = 8'h2f; // /
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: hdl/b36uid_step.sv
// per-character parse step: folds one character into the parse state
module b36uid_step
  import b36uid_pkg::*;
(
  input  parse_state_t state_i,
  input  in_item_t     item_i,
  output parse_state_t state_nxt,
  output out_item_t    result_o
);

  logic                is_num;
  logic                is_lower;
  logic [DIGIT_W-1:0]  digit;
  logic [WIDE_W-1:0]   acc_wide;
  logic [WIDE_W-1:0]   sum_wide;
  logic                ovf;
  parse_state_t        consumed;
  logic [STATUS_W-1:0] status;

  // digit decode
  always_comb begin
    is_num   = (item_i.char_code >= 8'h30) && (item_i.char_code <= 8'h39);
    is_lower = (item_i.char_code >= 8'h61) && (item_i.char_code <= 8'h7a);
    if (is_num) begin
      digit = DIGIT_W'(item_i.char_code - 8'h30);
    end else begin
      digit = DIGIT_W'(item_i.char_code - 8'h57);
    end
  end

  // acc * 36 + digit as (acc << 5) + (acc << 2) + digit
  always_comb begin
    acc_wide = {{(WIDE_W-VALUE_W){1'b0}}, state_i.acc};
    sum_wide = (acc_wide << 5) + (acc_wide << 2) + {{(WIDE_W-DIGIT_W){1'b0}}, digit};
    ovf      = |sum_wide[WIDE_W-1:VALUE_W];
  end

  // consume the character unless an error is already recorded
  always_comb begin
    consumed = state_i;
    if (state_i.err == ST_OK) begin
      if (state_i.prefix_pos < PREFIX_LEN) begin
        if (item_i.char_code != prefix_char(state_i.prefix_pos)) begin
          consumed.err = ST_BAD_PREFIX;
        end else begin
          consumed.prefix_pos = state_i.prefix_pos + 3'd1;
        end
      end else if (!(is_num || is_lower)) begin
        consumed.err = ST_BAD_DIGIT;
      end else if (ovf) begin
        consumed.err = ST_OVERFLOW;
      end else begin
        consumed.acc       = sum_wide[VALUE_W-1:0];
        consumed.body_seen = 1'b1;
      end
    end
  end

  // final status on the last character
  always_comb begin
    if (consumed.err != ST_OK) begin
      status = consumed.err;
    end else if (consumed.prefix_pos < PREFIX_LEN) begin
      status = ST_BAD_PREFIX;
    end else if (!consumed.body_seen) begin
      status = ST_EMPTY_BODY;
    end else begin
      status = ST_OK;
    end
    result_o.status = status;
    result_o.value  = (status == ST_OK) ? consumed.acc : '0;
    state_nxt       = item_i.last ? '0 : consumed;
  end

endmodule

FILE: hdl/base36_uid_parser_top.sv
// top level of the base-36 uid parser: input register, parse step, result register
// path: input register, parse step, then the result register behind out_valid
// throughput: one character per cycle; a last character waits in the input register
//   only while the previous result has not yet been transferred
// reset: rst_n (synchronous, active low) clears the parse state and both valid flags
module base36_uid_parser_top
  import b36uid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic         s1_valid_r;
  in_item_t     s1_data_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  out_item_t    result;
  logic         out_valid_r;
  out_item_t    out_data_r;
  logic         s1_adv;

  // the staged character moves on unless it carries a result with nowhere to go
  assign s1_adv   = s1_valid_r && (!s1_data_r.last || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  b36uid_step u_step (
    .state_i   (state_r),
    .item_i    (s1_data_r),
    .state_nxt (state_nxt),
    .result_o  (result)
  );

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_data_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_data_r.last) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an error result never carries a value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != ST_OK) |-> out_data_r.value == '0)
    else $error("error result with nonzero value");

  // the parse state is cleared after the last character
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_data_r.last |=> state_r == '0)
    else $error("state not cleared after last character");

  // the first error sticks until the string ends
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_data_r.last && (state_r.err != ST_OK) |=> state_r.err == $past(state_r.err))
    else $error("recorded error changed inside a string");

  // prefix position never passes the prefix length
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.prefix_pos <= PREFIX_LEN)
    else $error("prefix position out of range");

  // body digits only follow a complete prefix
  a_body_after_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.body_seen |-> state_r.prefix_pos == PREFIX_LEN)
    else $error("body digit seen before prefix complete");

endmodule

FILE: tb/b36uid_checker.sv
// checker for the base-36 uid parser: predicts each result and compares result transfers
`timescale 1ns / 1ps
module b36uid_checker
  import b36uid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        awaited
);

  localparam int MAX_REPORTS = 10;
  localparam int RADIX       = 36;
  localparam logic [47:0] UID_PREFIX = "uid://";

  // predicted parse state
  logic [POS_W-1:0]    pfx_matched;
  logic [VALUE_W-1:0]  acc;
  logic [STATUS_W-1:0] first_err;
  logic                got_digit;

  out_item_t expected_results[$];
  out_item_t want;
  int        errs;

  // base-36 digit value, -1 for anything else
  function automatic int b36_value(input logic [CHAR_W-1:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch - "0");
    if (ch >= "a" && ch <= "z") return int'(ch - "a") + 10;
    return -1;
  endfunction

  task automatic clear_parse();
    pfx_matched = '0;
    acc         = '0;
    first_err   = ST_OK;
    got_digit   = 1'b0;
  endtask

  // fold one character into the parse state, queue a result on the last one
  task automatic step_parse(input in_item_t item);
    int                  k;
    int                  d;
    logic [WIDE_W-1:0]   folded;
    logic [STATUS_W-1:0] st;
    out_item_t           res;
    if (first_err == ST_OK) begin
      if (pfx_matched < PREFIX_LEN) begin
        k = 5 - int'(pfx_matched);
        if (item.char_code != UID_PREFIX[8*k +: 8]) first_err = ST_BAD_PREFIX;
        else pfx_matched = pfx_matched + 3'd1;
      end else begin
        d = b36_value(item.char_code);
        if (d < 0) begin
          first_err = ST_BAD_DIGIT;
        end else begin
          folded = {6'd0, acc} * WIDE_W'(RADIX) + WIDE_W'(d);
          // anything above bit 63 means the value no longer fits
          if (folded[WIDE_W-1:VALUE_W] != '0) begin
            first_err = ST_OVERFLOW;
          end else begin
            acc       = folded[VALUE_W-1:0];
            got_digit = 1'b1;
          end
        end
      end
    end
    if (item.last) begin
      if (first_err != ST_OK) st = first_err;
      else if (pfx_matched < PREFIX_LEN) st = ST_BAD_PREFIX;
      else if (!got_digit) st = ST_EMPTY_BODY;
      else st = ST_OK;
      res.status = st;
      res.value  = (st == ST_OK) ? acc : '0;
      expected_results.insert(expected_results.size(), res);
      clear_parse();
    end
  endtask

  // watch both channels, predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      expected_results.delete();
      errs = 0;
      fail_count <= 0;
      awaited    <= 0;
    end else begin
      if (in_valid && in_ready) step_parse(in_data);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("[%0t] result with none expected: status %0d value %h",
                     $realtime, out_data.status, out_data.value);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status || out_data.value !== want.value) begin
            errs++;
            if (errs <= MAX_REPORTS)
              $display("[%0t] mismatch: status exp %0d got %0d, value exp %h got %h",
                       $realtime, want.status, out_data.status, want.value, out_data.value);
          end
        end
      end
      fail_count <= errs;
      awaited    <= expected_results.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// testbench top for the base-36 uid parser: clock, reset, character stimulus and verdict
`timescale 1ns / 1ps
module tb_top
  import b36uid_pkg::*;
();

  localparam int CHAR_BUDGET  = 750;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 21;
  localparam logic [47:0]  PREFIX_STR = "uid://";
  // 2^64-1 written in base 36
  localparam logic [103:0] MAX_B36  = "3w5e11264sgsf";

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        awaited;
  logic      idling_on;
  int        chars_sent;
  int        cycles;
  bit        drained_once;
  logic [CHAR_W-1:0] text[$];

  base36_uid_parser_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  b36uid_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst_n) out_ready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic logic [CHAR_W-1:0] digit_char(input int d);
    return (d < 10) ? 8'("0" + d) : 8'("a" + d - 10);
  endfunction

  // any byte that is not a lowercase base-36 digit, weighted toward uppercase and nul
  function automatic logic [CHAR_W-1:0] non_digit();
    logic [CHAR_W-1:0] ch;
    case ($urandom_range(5))
      0, 1:    ch = 8'("A" + $urandom_range(25));
      2:       ch = 8'h00;
      default: begin
        do ch = 8'($urandom_range(255));
        while ((ch >= "0" && ch <= "9") || (ch >= "a" && ch <= "z"));
      end
    endcase
    return ch;
  endfunction

  // append one character to the string being built
  task automatic add_char(input logic [CHAR_W-1:0] ch);
    text.insert(text.size(), ch);
  endtask

  task automatic push_prefix(input int n);
    for (int i = 0; i < n; i++) add_char(PREFIX_STR[8*(5-i) +: 8]);
  endtask

  // one character transfer, with random idle cycles ahead of it
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic is_last);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.char_code <= ch;
    in_data.last      <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
    text.delete();
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // one random identifier string, mostly well formed
  task automatic build_random();
    int                kind;
    int                pos;
    logic [CHAR_W-1:0] ch;
    kind = $urandom_range(99);
    if (kind < 50) begin
      push_prefix(6);
      repeat ($urandom_range(1, 12)) add_char(digit_char($urandom_range(35)));
    end else if (kind < 62) begin
      // values around the top of the 64-bit range
      push_prefix(6);
      for (int i = 0; i < 13; i++) add_char(MAX_B36[8*(12-i) +: 8]);
      case ($urandom_range(4))
        0: ;
        1: text[6 + $urandom_range(12)] = digit_char($urandom_range(35));
        2: text[18] = digit_char($urandom_range(35));
        3: text.insert(6, "0");
        default: add_char(digit_char($urandom_range(35)));
      endcase
    end else if (kind < 72) begin
      // text that stops inside the prefix or right after it
      push_prefix($urandom_range(1, 6));
    end else if (kind < 85) begin
      push_prefix(6);
      repeat ($urandom_range(0, 4)) add_char(digit_char($urandom_range(35)));
      add_char(non_digit());
      repeat ($urandom_range(0, 4)) add_char(8'($urandom_range(255)));
    end else if (kind < 95) begin
      // one prefix character corrupted
      push_prefix(6);
      pos = $urandom_range(5);
      do ch = 8'($urandom_range(255));
      while (ch == text[pos]);
      text[pos] = ch;
      repeat ($urandom_range(0, 6))
        add_char($urandom_range(1) ? digit_char($urandom_range(35))
                                   : 8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(255)));
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    out_ready    <= 1'b0;
    idling_on    <= 1'b1;
    chars_sent   = 0;
    drained_once = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // top byte as the only character
    add_char(8'hff);
    send_text();
    // text ends inside the prefix
    push_prefix(3);
    send_text();
    // empty body
    push_prefix(6);
    send_text();
    // uppercase digit, then a character that must be ignored
    push_prefix(6);
    add_char("A");
    add_char("0");
    send_text();
    // nul in the body
    push_prefix(6);
    add_char(8'h00);
    send_text();

    while (chars_sent < CHAR_BUDGET) begin
      idling_on <= !(chars_sent >= 300 && chars_sent < 450);
      if (!drained_once && chars_sent >= 500) begin
        wait_for_results();
        drained_once = 1'b1;
      end
      build_random();
      send_text();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: base36_uid_parser_top.f
hdl/b36uid_pkg.sv
hdl/b36uid_step.sv
hdl/base36_uid_parser_top.sv
tb/b36uid_checker.sv
tb/tb_top.sv
